@@ hdl/spq_pkg.sv @@
// shared types and constants for the stable priority queue
`default_nettype none
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int PRIO_W          = 8;
    localparam int TAG_W           = 16;
    localparam int OCC_W           = 7;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_DROPPED = 2'd1,
        ST_SERVED  = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    // operation broadcast to every cell in parallel
    typedef struct packed {
        logic   do_add;
        logic   do_remove;
        t_entry item;
    } t_cell_cmd;

endpackage
`default_nettype wire

@@ hdl/spq_if.sv @@
// request and response channel interfaces
`default_nettype none
interface spq_req_if import spq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [PRIO_W-1:0] job_priority;
    logic [TAG_W-1:0]  job_tag;

    modport source (output valid, kind, job_priority, job_tag, input ready);
    modport sink   (input valid, kind, job_priority, job_tag, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [PRIO_W-1:0] served_priority;
    logic [TAG_W-1:0]  served_tag;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, status, served_priority, served_tag, occupancy,
                    input ready);
    modport sink   (input valid, status, served_priority, served_tag, occupancy,
                    output ready);
endinterface
`default_nettype wire

@@ hdl/spq_cell.sv @@
// one slot of the sorted queue: holds an entry and trades with its neighbors
`default_nettype none
module spq_cell import spq_pkg::*; #(
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  wire              i_clk,
    input  wire t_cell_cmd   i_cmd,
    input  wire [CNT_W-1:0]  i_count,
    input  wire              i_prev_keep,
    input  wire t_entry      i_prev_entry,
    input  wire t_entry      i_next_entry,
    output logic             o_keep,
    output t_entry           o_entry
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_occupied;

    assign w_occupied = CNT_W'(IDX) < i_count;
    // on an add, an occupied entry stays put when it ranks at or above the new job
    assign o_keep     = w_occupied && (r_entry.prio >= i_cmd.item.prio);
    assign o_entry    = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.do_add) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_prev_keep) begin
                n_entry = i_cmd.item;
            end else begin
                n_entry = i_prev_entry;
            end
        end else if (i_cmd.do_remove) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire

@@ hdl/stable_priority_queue_top.sv @@
// top level of the stable priority queue
`default_nettype none
// Sorted priority queue built as a row of QUEUE_DEPTH cells, head in cell 0.
// Every cell compares its entry with the incoming job in parallel and either
// holds, takes the new job or takes its neighbor's entry, so an add or a
// remove updates all cells at once: one request beat is accepted per cycle
// while ready, and its response beat appears in the output register on the
// next cycle. The request side stays ready whenever the output register is
// empty or being drained. Jobs of equal priority leave in arrival order; an
// add to a full queue is dropped and reported, a remove on an empty queue
// reports empty. Occupancy is the low 7 bits of the job count.
module stable_priority_queue_top import spq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    spq_req_if.sink    i_req,
    spq_rsp_if.source  o_rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    t_status            r_status;
    t_status            n_status;
    t_entry             r_served;
    t_entry             n_served;
    logic [OCC_W-1:0]   r_occ;
    logic [CNT_W+OCC_W-1:0] w_occ_ext;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    t_cell_cmd w_cmd;
    t_entry    w_entry [QUEUE_DEPTH];
    logic      w_keep  [QUEUE_DEPTH];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = r_count == CNT_W'(QUEUE_DEPTH);
    assign w_empty     = r_count == '0;

    assign w_cmd.do_add    = w_accept && (i_req.kind == KIND_ADD) && !w_full;
    assign w_cmd.do_remove = w_accept && (i_req.kind == KIND_REMOVE) && !w_empty;
    assign w_cmd.item.prio = i_req.job_priority;
    assign w_cmd.item.tag  = i_req.job_tag;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            spq_cell #(
                .CNT_W (CNT_W),
                .IDX   (gi)
            ) u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd),
                .i_count      (r_count),
                .i_prev_keep  ((gi == 0) ? 1'b1 : w_keep[(gi == 0) ? 0 : gi-1]),
                .i_prev_entry (w_entry[(gi == 0) ? 0 : gi-1]),
                .i_next_entry (w_entry[(gi == QUEUE_DEPTH-1) ? gi : gi+1]),
                .o_keep       (w_keep[gi]),
                .o_entry      (w_entry[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_served = '0;
        if (i_req.kind == KIND_ADD) begin
            n_status = w_full ? ST_DROPPED : ST_ADDED;
            if (!w_full) begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            n_status = w_empty ? ST_EMPTY : ST_SERVED;
            if (!w_empty) begin
                n_count  = r_count - CNT_W'(1);
                n_served = w_entry[0];
            end
        end
    end

    assign w_occ_ext = {{OCC_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_served <= n_served;
            r_occ    <= w_occ_ext[OCC_W-1:0];
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.served_priority = r_served.prio;
    assign o_rsp.served_tag      = r_served.tag;
    assign o_rsp.occupancy       = r_occ;

endmodule
`default_nettype wire

@@ hdl/spq_checker.sv @@
// port-level checks for the stable priority queue, bound to the top level
`default_nettype none
module spq_checker import spq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_rsp_valid,
    input wire              i_rsp_ready,
    input wire [1:0]        i_status,
    input wire [PRIO_W-1:0] i_served_priority,
    input wire [TAG_W-1:0]  i_served_tag,
    input wire [OCC_W-1:0]  i_occupancy
);

    localparam int OCC_FULL_W = OCC_W + 11;
    localparam logic [OCC_FULL_W-1:0] DEPTH_EXT = OCC_FULL_W'(QUEUE_DEPTH);

    // a pending response beat stays until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response beat dropped while stalled");

    a_no_served_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status != ST_SERVED) |->
            (i_served_priority == '0) && (i_served_tag == '0))
        else $error("served fields nonzero without a served job");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == ST_EMPTY) |-> i_occupancy == '0)
        else $error("empty report with nonzero occupancy");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == ST_DROPPED) |->
            i_occupancy == DEPTH_EXT[OCC_W-1:0])
        else $error("drop reported while queue not full");

endmodule

bind stable_priority_queue_top spq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_status          (o_rsp.status),
    .i_served_priority (o_rsp.served_priority),
    .i_served_tag      (o_rsp.served_tag),
    .i_occupancy       (o_rsp.occupancy)
);
`default_nettype wire
